@@ hdl/ptpr_pkg.sv @@
// Shared types, constants and pipeline step functions for the three-point parabola root finder.
package ptpr_pkg;

   // Iterations of each pipelined divider and of the square root unit.
   localparam int STEPS = 64;
   // 1.0 in Q8.24.
   localparam logic signed [63:0] Q24_ONE = 64'sd16777216;
   localparam logic signed [63:0] SAT_HI = 64'sh000000007FFFFFFF;
   localparam logic signed [63:0] SAT_LO = 64'shFFFFFFFF80000000;

   // Restoring divider state: dividend bits shift out of w as quotient bits shift in.
   typedef struct packed {
      logic [63:0] w;
      logic [33:0] rem;
   } div_type;

   // Digit-by-digit square root state.
   typedef struct packed {
      logic [127:0] rad;
      logic [65:0]  rem;
      logic [63:0]  root;
   } sq_type;

   // Values carried beside the first bank of iterative units.
   typedef struct packed {
      logic [33:0] aa;
      logic        a_neg;
      logic        b_neg;
      logic [31:0] c;
      logic        pos;
      logic        flat;
   } p1_side_type;

   // Values carried beside the second divider.
   typedef struct packed {
      logic [33:0]        aa;
      logic signed [63:0] xe;
      logic signed [63:0] ye30;
      logic               pos;
      logic               flat;
   } p2_side_type;

   // One quotient bit per call.
   function automatic div_type div_step(div_type s, logic [33:0] d);
      logic [34:0] t;
      div_type     r;
      t = {s.rem, s.w[63]};
      if (t >= {1'b0, d}) begin
         r.rem = 34'(t - {1'b0, d});
         r.w   = {s.w[62:0], 1'b1};
      end else begin
         r.rem = t[33:0];
         r.w   = {s.w[62:0], 1'b0};
      end
      return r;
   endfunction

   // One root bit per call.
   function automatic sq_type sqrt_step(sq_type s);
      logic [67:0] sr;
      logic [67:0] trial;
      sq_type      r;
      sr    = {s.rem, s.rad[127:126]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[125:0], 2'b00};
      if (sr >= trial) begin
         r.rem  = 66'(sr - trial);
         r.root = {s.root[62:0], 1'b1};
      end else begin
         r.rem  = sr[65:0];
         r.root = {s.root[62:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(logic signed [63:0] v);
      logic [31:0] r;
      if (v > SAT_HI) begin
         r = 32'h7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/parabola_three_point_roots.sv @@
// Throughput: one transaction per clock cycle, except while the output register holds a
// result that the receiver has not yet taken; every stage is one register deep.
// The depth is set by two chained banks of 64 bit-per-stage units: the square root
// of the discriminant (beside the vertex dividers) followed by the root-offset divider.
// Reset (synchronous, active high) clears every valid bit; payload registers are not reset.
module parabola_three_point_roots (
   input  logic         clock,
   input  logic         reset,
   // sample_minus [31:0], sample_center [63:32], sample_plus [95:64]
   input  logic [95:0]  req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // extreme_x [31:0], extreme_y [63:32], root_low [95:64], root_high [127:96],
   // root_count [129:128], zero fill [135:130]
   output logic [135:0] rsp_tdata,
   // degenerate [0]
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);

   // The whole pipeline advances together; it halts only while the output register
   // holds a result that the receiver has not yet taken.
   logic rsp_tvalid_ff;
   logic en;
   assign en = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // Stage 1: curvature and slope terms, 2a = M + P - 2C and 2b = P - M.
   logic        s1_v_ff;
   logic [33:0] s1_a2_ff, s1_a2_in;
   logic [32:0] s1_b2_ff, s1_b2_in;
   logic [31:0] s1_c_ff;
   logic [31:0] in_m, in_c, in_p;

   assign in_m = req_tdata[31:0];
   assign in_c = req_tdata[63:32];
   assign in_p = req_tdata[95:64];
   assign s1_a2_in = {{2{in_m[31]}}, in_m} + {{2{in_p[31]}}, in_p} - {in_c[31], in_c, 1'b0};
   assign s1_b2_in = {in_p[31], in_p} - {in_m[31], in_m};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a2_ff <= s1_a2_in;
         s1_b2_ff <= s1_b2_in;
         s1_c_ff  <= in_c;
      end
   end

   // Stage 2: magnitudes and signs. The flat-curve case is detected here.
   logic        s2_v_ff;
   logic [33:0] s2_aa_ff;
   logic [32:0] s2_bb_ff;
   logic [31:0] s2_cmag_ff;
   logic [31:0] s2_c_ff;
   logic        s2_an_ff, s2_bn_ff, s2_flat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_aa_ff   <= s1_a2_ff[33] ? 34'(-s1_a2_ff) : s1_a2_ff;
         s2_bb_ff   <= s1_b2_ff[32] ? 33'(-s1_b2_ff) : s1_b2_ff;
         s2_cmag_ff <= s1_c_ff[31] ? 32'(-s1_c_ff) : s1_c_ff;
         s2_c_ff    <= s1_c_ff;
         s2_an_ff   <= s1_a2_ff[33];
         s2_bn_ff   <= s1_b2_ff[32];
         s2_flat_ff <= (s1_a2_ff == '0);
      end
   end

   // Stage 3: the two products, b2^2 and |2a| * |c|.
   logic        s3_v_ff;
   logic [65:0] bsq_w, pc_w;
   logic [63:0] s3_bsq_ff;
   logic [64:0] s3_pc_ff;
   logic [33:0] s3_aa_ff;
   logic [32:0] s3_bb_ff;
   logic [31:0] s3_c_ff;
   logic        s3_an_ff, s3_bn_ff, s3_flat_ff;

   assign bsq_w = s2_bb_ff * s2_bb_ff;
   assign pc_w  = s2_aa_ff * s2_cmag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_bsq_ff  <= bsq_w[63:0];
         s3_pc_ff   <= pc_w[64:0];
         s3_aa_ff   <= s2_aa_ff;
         s3_bb_ff   <= s2_bb_ff;
         s3_c_ff    <= s2_c_ff;
         s3_an_ff   <= s2_an_ff;
         s3_bn_ff   <= s2_bn_ff;
         s3_flat_ff <= s2_flat_ff;
      end
   end

   // Stage 4: discriminant D4 = b2^2 - 8*a2*c. When a and c share a sign the product
   // is subtracted and positivity is a compare; otherwise it adds.
   logic [68:0] bsq69, prod69, d4_in;
   logic        pos_in, same_sign;

   assign bsq69     = {5'b0, s3_bsq_ff};
   assign prod69    = {1'b0, s3_pc_ff, 3'b000};
   assign same_sign = (s3_c_ff != '0) && (s3_an_ff == s3_c_ff[31]);

   always_comb begin
      if (same_sign) begin
         pos_in = bsq69 > prod69;
         d4_in  = bsq69 - prod69;
      end else begin
         d4_in  = bsq69 + prod69;
         pos_in = (d4_in != '0);
      end
   end

   // First bank: vertex divider, vertex-value divider and square root, side by side.
   logic                      p1_v_ff    [0:ptpr_pkg::STEPS];
   ptpr_pkg::p1_side_type     p1_side_ff [0:ptpr_pkg::STEPS];
   ptpr_pkg::div_type         p1_xd_ff   [0:ptpr_pkg::STEPS];
   ptpr_pkg::div_type         p1_qd_ff   [0:ptpr_pkg::STEPS];
   ptpr_pkg::sq_type          p1_sq_ff   [0:ptpr_pkg::STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff[0] <= 1'b0;
      end else if (en) begin
         p1_v_ff[0] <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff[0].aa    <= s3_aa_ff;
         p1_side_ff[0].a_neg <= s3_an_ff;
         p1_side_ff[0].b_neg <= s3_bn_ff;
         p1_side_ff[0].c     <= s3_c_ff;
         p1_side_ff[0].pos   <= pos_in;
         p1_side_ff[0].flat  <= s3_flat_ff;
         // |b2| * 2^23 over |a2| gives the vertex x in Q8.24.
         p1_xd_ff[0].w       <= {8'b0, s3_bb_ff, 23'b0};
         p1_xd_ff[0].rem     <= '0;
         // b2^2 / (8 |a2|) equals (b2^2 >> 3) / |a2| under floor.
         p1_qd_ff[0].w       <= {3'b0, s3_bsq_ff[63:3]};
         p1_qd_ff[0].rem     <= '0;
         p1_sq_ff[0].rad     <= {13'b0, d4_in, 46'b0};
         p1_sq_ff[0].rem     <= '0;
         p1_sq_ff[0].root    <= '0;
      end
   end

   for (genvar k = 0; k < ptpr_pkg::STEPS; k++) begin : g_p1
      always_ff @(posedge clock) begin
         if (reset) begin
            p1_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            p1_v_ff[k+1] <= p1_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p1_side_ff[k+1] <= p1_side_ff[k];
            p1_xd_ff[k+1]   <= ptpr_pkg::div_step(p1_xd_ff[k], p1_side_ff[k].aa);
            p1_qd_ff[k+1]   <= ptpr_pkg::div_step(p1_qd_ff[k], p1_side_ff[k].aa);
            p1_sq_ff[k+1]   <= ptpr_pkg::sqrt_step(p1_sq_ff[k]);
         end
      end
   end

   // Between the banks: round the vertex x (ties away from zero on the magnitude),
   // form the vertex value in units of 2^-30, and load the root-offset divider.
   ptpr_pkg::p1_side_type p1_end;
   ptpr_pkg::div_type     xd_end, qd_end;
   logic [63:0]           xmag;
   logic signed [63:0]    xe_in, ye30_in, c64;

   assign p1_end = p1_side_ff[ptpr_pkg::STEPS];
   assign xd_end = p1_xd_ff[ptpr_pkg::STEPS];
   assign qd_end = p1_qd_ff[ptpr_pkg::STEPS];
   assign xmag   = xd_end.w + 64'({xd_end.rem, 1'b0} >= {1'b0, p1_end.aa});
   assign xe_in  = (p1_end.a_neg == p1_end.b_neg) ? -$signed(xmag) : $signed(xmag);
   assign c64    = $signed({{32{p1_end.c[31]}}, p1_end.c});
   assign ye30_in = p1_end.a_neg ? c64 + $signed(qd_end.w) : c64 - $signed(qd_end.w);

   logic                  p2_v_ff    [0:ptpr_pkg::STEPS];
   ptpr_pkg::p2_side_type p2_side_ff [0:ptpr_pkg::STEPS];
   ptpr_pkg::div_type     p2_dd_ff   [0:ptpr_pkg::STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff[0] <= 1'b0;
      end else if (en) begin
         p2_v_ff[0] <= p1_v_ff[ptpr_pkg::STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_side_ff[0].aa   <= p1_end.aa;
         p2_side_ff[0].xe   <= xe_in;
         p2_side_ff[0].ye30 <= ye30_in;
         p2_side_ff[0].pos  <= p1_end.pos;
         p2_side_ff[0].flat <= p1_end.flat;
         p2_dd_ff[0].w      <= p1_sq_ff[ptpr_pkg::STEPS].root;
         p2_dd_ff[0].rem    <= '0;
      end
   end

   // Second bank: sqrt(D4 * 2^46) over |a2| gives the root half-spread in Q8.24.
   for (genvar k = 0; k < ptpr_pkg::STEPS; k++) begin : g_p2
      always_ff @(posedge clock) begin
         if (reset) begin
            p2_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            p2_v_ff[k+1] <= p2_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p2_side_ff[k+1] <= p2_side_ff[k];
            p2_dd_ff[k+1]   <= ptpr_pkg::div_step(p2_dd_ff[k], p2_side_ff[k].aa);
         end
      end
   end

   // Finish 1: round the half-spread (ties up) and take the vertex value magnitude.
   ptpr_pkg::p2_side_type p2_end;
   ptpr_pkg::div_type     dd_end;
   logic                  f1_v_ff;
   logic signed [63:0]    f1_xe_ff, f1_dx_ff;
   logic [63:0]           f1_yabs_ff;
   logic                  f1_yneg_ff, f1_pos_ff, f1_flat_ff;

   assign p2_end = p2_side_ff[ptpr_pkg::STEPS];
   assign dd_end = p2_dd_ff[ptpr_pkg::STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= p2_v_ff[ptpr_pkg::STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_xe_ff   <= p2_end.xe;
         f1_dx_ff   <= $signed(dd_end.w + 64'({dd_end.rem, 1'b0} >= {1'b0, p2_end.aa}));
         f1_yabs_ff <= p2_end.ye30[63] ? 64'(-p2_end.ye30) : 64'(p2_end.ye30);
         f1_yneg_ff <= p2_end.ye30[63];
         f1_pos_ff  <= p2_end.pos;
         f1_flat_ff <= p2_end.flat;
      end
   end

   // Finish 2: the two roots, and the vertex value brought to Q8.24 (ties away from zero).
   logic               f2_v_ff;
   logic signed [63:0] f2_xe_ff, f2_ye_ff, f2_z1_ff, f2_z2_ff;
   logic               f2_pos_ff, f2_flat_ff;
   logic [63:0]        ymag;

   assign ymag = (f1_yabs_ff + 64'd32) >> 6;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_v_ff <= 1'b0;
      end else if (en) begin
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2_xe_ff   <= f1_xe_ff;
         f2_ye_ff   <= f1_yneg_ff ? -$signed(ymag) : $signed(ymag);
         f2_z1_ff   <= f1_xe_ff - f1_dx_ff;
         f2_z2_ff   <= f1_xe_ff + f1_dx_ff;
         f2_pos_ff  <= f1_pos_ff;
         f2_flat_ff <= f1_flat_ff;
      end
   end

   // Output register: range tests on the unsaturated roots, the lower root replaced when
   // it lies below -1, saturation, and the flat-curve and no-root overrides.
   logic [135:0]       rsp_tdata_ff, rsp_tdata_in;
   logic               rsp_tuser_ff;
   logic               z1_in_range, z2_in_range, z1_below;
   logic [1:0]         count_in;
   logic signed [63:0] z1_sel, z2_sel;

   always_comb begin
      z1_in_range = (f2_z1_ff >= -ptpr_pkg::Q24_ONE) && (f2_z1_ff <= ptpr_pkg::Q24_ONE);
      z2_in_range = (f2_z2_ff >= -ptpr_pkg::Q24_ONE) && (f2_z2_ff <= ptpr_pkg::Q24_ONE);
      z1_below    = f2_z1_ff < -ptpr_pkg::Q24_ONE;
      if (f2_pos_ff) begin
         count_in = 2'(z1_in_range) + 2'(z2_in_range);
         z1_sel   = z1_below ? f2_z2_ff : f2_z1_ff;
         z2_sel   = f2_z2_ff;
      end else begin
         count_in = '0;
         z1_sel   = '0;
         z2_sel   = '0;
      end
      if (f2_flat_ff) begin
         rsp_tdata_in = '0;
      end else begin
         rsp_tdata_in = {6'b0, count_in, ptpr_pkg::sat32(z2_sel), ptpr_pkg::sat32(z1_sel),
                         ptpr_pkg::sat32(f2_ye_ff), ptpr_pkg::sat32(f2_xe_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= f2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= f2_flat_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   // A flat curve carries nothing but the degenerate flag.
   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate result carries nonzero data");

   // At most two roots can be counted.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[129:128] != 2'd3)
      else $error("root count out of range");

   // Two counted roots are both in [-1, 1], so the lower one was kept and is ordered.
   a_root_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[129:128] == 2'd2 |->
         $signed(rsp_tdata[95:64]) <= $signed(rsp_tdata[127:96]))
      else $error("roots out of order");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule
